FILE: hdl/tlhe_pkg.sv
// Shared types and constants of the thick line hexagon expander.
`timescale 1ns / 1ps
package tlhe_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int MAT_WORDS     = 48;

	localparam logic [5:0] BASE_WVP  = 6'd0;
	localparam logic [5:0] BASE_WV   = 6'd16;
	localparam logic [5:0] BASE_PROJ = 6'd32;

	localparam logic [2:0] CFG_MODE   = 3'd0;
	localparam logic [2:0] CFG_VIEW_W = 3'd1;
	localparam logic [2:0] CFG_HALF_X = 3'd2;
	localparam logic [2:0] CFG_HALF_Y = 3'd3;
	localparam logic [2:0] CFG_MIN_X  = 3'd4;
	localparam logic [2:0] CFG_MIN_Y  = 3'd5;

	localparam logic [30:0] VIEW_WIDTH_RST = 31'd65536;

	typedef enum logic [3:0] {
		U_MAC, U_HW, U_HH, U_HS, U_MW, U_MH, U_P0, U_P1, U_P2, U_P3
	} uop_t;

	typedef enum logic [2:0] {V_VIN, V_VC, V_TL, V_C, V_TC} vec_t;

	typedef struct packed {
		logic       load_word;
		logic       latch_vtx;
		logic       mul_valid;
		uop_t       uop;
		vec_t       src;
		vec_t       dst;
		logic [1:0] i;
		logic [1:0] j;
		logic [5:0] addr;
		logic       tl_en;
		logic       ext_en;
		logic       ep_en;
		logic       ep_e1;
		logic       sel_en;
		logic [2:0] k;
	} dp_cmd_t;

	typedef struct packed {
		logic mode;
	} dp_stat_t;

endpackage

FILE: hdl/tlhe_ctrl.sv
// Sequencer of the thick line hexagon expander: steps the shared multiplier and the datapath.
`timescale 1ns / 1ps
module tlhe_ctrl
	import tlhe_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  logic     op,
	output logic     out_valid,
	input  logic     out_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_XF1, S_WAIT, S_SCL, S_HS, S_TL, S_XF2, S_MIN, S_EXT, S_EP,
		S_XP, S_SEL, S_EMIT
	} state_t;

	state_t     state_q, nxt_q;
	logic [4:0] cnt_q;
	logic       phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			nxt_q   <= S_IDLE;
			cnt_q   <= '0;
			phase_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && op) begin
						state_q <= S_XF1;
						cnt_q   <= '0;
					end
				end
				S_XF1: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd15) begin
						state_q <= S_WAIT;
						cnt_q   <= 5'd1;
						nxt_q   <= stat.mode ? S_SCL : S_HS;
					end
				end
				S_WAIT: begin
					if (cnt_q == 5'd0) state_q <= nxt_q;
					else cnt_q <= cnt_q - 5'd1;
				end
				S_SCL, S_MIN: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd1) begin
						state_q <= S_WAIT;
						cnt_q   <= 5'd1;
						nxt_q   <= (state_q == S_SCL) ? S_EP : S_EXT;
					end
				end
				S_HS: begin
					state_q <= S_WAIT;
					cnt_q   <= 5'd1;
					nxt_q   <= S_TL;
				end
				S_TL: begin
					state_q <= S_XF2;
					cnt_q   <= '0;
				end
				S_XF2: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= S_MIN;
						cnt_q   <= '0;
					end
				end
				S_EXT: state_q <= S_EP;
				S_EP: begin
					if (phase_q) begin
						state_q <= S_XP;
						cnt_q   <= '0;
					end else begin
						phase_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_XP: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd3) begin
						state_q <= S_WAIT;
						cnt_q   <= 5'd1;
						nxt_q   <= S_SEL;
					end
				end
				S_SEL: begin
					state_q <= S_EMIT;
					cnt_q   <= '0;
				end
				S_EMIT: begin
					if (!out_stall) begin
						if (cnt_q == 5'd5) begin
							state_q <= S_IDLE;
							phase_q <= 1'b0;
						end else begin
							cnt_q <= cnt_q + 5'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_EMIT);

	always_comb begin
		cmd           = '0;
		cmd.uop       = U_MAC;
		cmd.src       = V_VIN;
		cmd.dst       = V_C;
		cmd.k         = cnt_q[2:0];
		cmd.ep_e1     = phase_q;
		cmd.load_word = (state_q == S_IDLE) && in_valid && !op;
		cmd.latch_vtx = (state_q == S_IDLE) && in_valid && op;
		unique case (state_q)
			S_XF1: begin
				cmd.mul_valid = 1'b1;
				cmd.dst       = stat.mode ? V_C : V_VC;
				cmd.j         = cnt_q[3:2];
				cmd.i         = cnt_q[1:0];
				cmd.addr      = (stat.mode ? BASE_WVP : BASE_WV) + {2'b00, cnt_q[1:0], cnt_q[3:2]};
			end
			S_XF2: begin
				cmd.mul_valid = 1'b1;
				cmd.src       = cnt_q[4] ? V_TL : V_VC;
				cmd.dst       = cnt_q[4] ? V_TC : V_C;
				cmd.j         = cnt_q[3:2];
				cmd.i         = cnt_q[1:0];
				cmd.addr      = BASE_PROJ + {2'b00, cnt_q[1:0], cnt_q[3:2]};
			end
			S_SCL: begin
				cmd.mul_valid = 1'b1;
				cmd.uop       = cnt_q[0] ? U_HH : U_HW;
			end
			S_MIN: begin
				cmd.mul_valid = 1'b1;
				cmd.uop       = cnt_q[0] ? U_MH : U_MW;
			end
			S_HS: begin
				cmd.mul_valid = 1'b1;
				cmd.uop       = U_HS;
			end
			S_XP: begin
				cmd.mul_valid = 1'b1;
				unique case (cnt_q[1:0])
					2'd0: cmd.uop = U_P0;
					2'd1: cmd.uop = U_P1;
					2'd2: cmd.uop = U_P2;
					default: cmd.uop = U_P3;
				endcase
			end
			S_TL:  cmd.tl_en  = 1'b1;
			S_EXT: cmd.ext_en = 1'b1;
			S_EP:  cmd.ep_en  = 1'b1;
			S_SEL: cmd.sel_en = 1'b1;
			default: ;
		endcase
	end

endmodule

FILE: hdl/tlhe_dpath.sv
// Datapath of the thick line hexagon expander: matrix memory, shared multiplier, endpoint registers.
`timescale 1ns / 1ps
module tlhe_dpath
	import tlhe_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [30:0]        cfg_wdata,
	input  logic [5:0]         word_index,
	input  logic signed [31:0] word_value,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] tex_u,
	input  logic signed [31:0] tex_v,
	input  logic [31:0]        rgba,
	output logic signed [31:0] clip_x,
	output logic signed [31:0] clip_y,
	output logic signed [31:0] clip_z,
	output logic signed [31:0] clip_w,
	output logic signed [31:0] out_u,
	output logic signed [31:0] out_v,
	output logic [31:0]        out_rgba,
	output logic               last
);

	typedef struct packed {
		logic signed [31:0] l, r, t, b, z, w, u, v;
		logic [31:0]        color;
	} endpoint_t;

	typedef struct packed {
		uop_t       uop;
		vec_t       dst;
		logic [1:0] i;
		logic [1:0] j;
	} tag_t;

	// Corner codes: bit 0 picks right over left, bit 1 bottom over top.
	localparam logic [1:0] CORNER_ORDER [4][6] = '{
		'{2'd3, 2'd2, 2'd0, 2'd0, 2'd1, 2'd3},
		'{2'd1, 2'd3, 2'd2, 2'd2, 2'd0, 2'd1},
		'{2'd2, 2'd0, 2'd1, 2'd1, 2'd3, 2'd2},
		'{2'd0, 2'd1, 2'd3, 2'd3, 2'd2, 2'd0}
	};

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
		input logic signed [31:0] b);
		return sat32(64'(a) + 64'(b));
	endfunction

	function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
		input logic signed [31:0] b);
		return sat32(64'(a) - 64'(b));
	endfunction

	function automatic logic signed [31:0] abs_diff(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [33:0] d;
		d = 34'(a) - 34'(b);
		if (d < 0) d = -d;
		return sat32(64'(d));
	endfunction

	logic [31:0] mem [MAT_WORDS];

	logic               mode_q;
	logic [30:0]        view_w_q, half_x_q, half_y_q, min_x_q, min_y_q;
	logic signed [31:0] vin_q [4];
	logic signed [31:0] vc_q  [4];
	logic signed [31:0] tl_q  [4];
	logic signed [31:0] c_q   [4];
	logic signed [31:0] tc_q  [4];
	logic signed [31:0] hw_q, hh_q, hs_q, mw_q, mh_q;
	logic signed [63:0] p_q [4];
	logic signed [31:0] u_q, v_q;
	logic [31:0]        color_q;
	endpoint_t          e0_q, e1_q;
	logic [1:0]         sel_q;

	logic               valid_s1, valid_s2;
	tag_t               tag_s1, tag_s2;
	logic signed [31:0] a_s1, bop_s1, mem_s1;
	logic signed [63:0] prod_s2;
	logic signed [33:0] acc_q;

	assign stat.mode = mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			view_w_q <= VIEW_WIDTH_RST;
			half_x_q <= '0;
			half_y_q <= '0;
			min_x_q  <= '0;
			min_y_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE:   mode_q   <= cfg_wdata[0];
				CFG_VIEW_W: view_w_q <= cfg_wdata;
				CFG_HALF_X: half_x_q <= cfg_wdata;
				CFG_HALF_Y: half_y_q <= cfg_wdata;
				CFG_MIN_X:  min_x_q  <= cfg_wdata;
				CFG_MIN_Y:  min_y_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_word && (word_index < 6'(MAT_WORDS))) mem[word_index] <= word_value;
		mem_s1 <= mem[cmd.addr];
	end

	// Operand fetch stage.
	logic signed [31:0] a_c, b_c;
	always_comb begin
		a_c = '0;
		b_c = c_q[3];
		unique case (cmd.uop)
			U_MAC: begin
				unique case (cmd.src)
					V_VC:    a_c = vc_q[cmd.i];
					V_TL:    a_c = tl_q[cmd.i];
					default: a_c = vin_q[cmd.i];
				endcase
			end
			U_HW: a_c = {1'b0, half_x_q};
			U_HH: a_c = {1'b0, half_y_q};
			U_HS: begin
				a_c = {1'b0, view_w_q};
				b_c = vc_q[3];
			end
			U_MW: a_c = {1'b0, min_x_q};
			U_MH: a_c = {1'b0, min_y_q};
			U_P0: begin
				a_c = e0_q.t;
				b_c = e1_q.w;
			end
			U_P1: begin
				a_c = e1_q.t;
				b_c = e0_q.w;
			end
			U_P2: begin
				a_c = e0_q.l;
				b_c = e1_q.w;
			end
			U_P3: begin
				a_c = e1_q.l;
				b_c = e0_q.w;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.mul_valid;
			valid_s2 <= valid_s1;
		end
	end

	logic signed [63:0] prod_c;
	assign prod_c = (tag_s1.uop == U_MAC) ? a_s1 * mem_s1 : a_s1 * bop_s1;

	always_ff @(posedge clk) begin
		tag_s1  <= '{uop: cmd.uop, dst: cmd.dst, i: cmd.i, j: cmd.j};
		a_s1    <= a_c;
		bop_s1  <= b_c;
		tag_s2  <= tag_s1;
		prod_s2 <= prod_c;
	end

	// Write-back stage: scale, saturate, accumulate.
	logic signed [31:0] q_c, h_c, col_c;
	logic signed [33:0] acc_sum;
	assign q_c     = sat32(prod_s2 >>> FRAC_BITS);
	assign h_c     = sat32(prod_s2 >>> (FRAC_BITS + 1));
	assign acc_sum = (tag_s2.i == 2'd0) ? 34'(q_c) : acc_q + 34'(q_c);
	assign col_c   = sat32(64'(acc_sum));

	logic signed [31:0] ext_w_c, ext_h_c;
	assign ext_w_c = abs_diff(tc_q[0], c_q[0]);
	assign ext_h_c = abs_diff(tc_q[1], c_q[1]);

	endpoint_t ep_c;
	always_comb begin
		ep_c.l     = sat_sub(c_q[0], hw_q);
		ep_c.r     = sat_add(c_q[0], hw_q);
		ep_c.t     = sat_add(c_q[1], hh_q);
		ep_c.b     = sat_sub(c_q[1], hh_q);
		ep_c.z     = c_q[2];
		ep_c.w     = c_q[3];
		ep_c.u     = u_q;
		ep_c.v     = v_q;
		ep_c.color = color_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_vtx) begin
			vin_q[0] <= pos_x;
			vin_q[1] <= pos_y;
			vin_q[2] <= pos_z;
			vin_q[3] <= 32'sd1 <<< FRAC_BITS;
			u_q      <= tex_u;
			v_q      <= tex_v;
			color_q  <= rgba;
		end
		if (valid_s2) begin
			unique case (tag_s2.uop)
				U_MAC: begin
					acc_q <= acc_sum;
					if (tag_s2.i == 2'd3) begin
						unique case (tag_s2.dst)
							V_VC:    vc_q[tag_s2.j] <= col_c;
							V_TC:    tc_q[tag_s2.j] <= col_c;
							default: c_q[tag_s2.j]  <= col_c;
						endcase
					end
				end
				U_HW: hw_q <= q_c;
				U_HH: hh_q <= q_c;
				U_HS: hs_q <= h_c;
				U_MW: mw_q <= q_c;
				U_MH: mh_q <= q_c;
				U_P0: p_q[0] <= prod_s2;
				U_P1: p_q[1] <= prod_s2;
				U_P2: p_q[2] <= prod_s2;
				U_P3: p_q[3] <= prod_s2;
				default: ;
			endcase
		end
		if (cmd.tl_en) begin
			tl_q[0] <= sat_sub(vc_q[0], hs_q);
			tl_q[1] <= sat_add(vc_q[1], hs_q);
			tl_q[2] <= vc_q[2];
			tl_q[3] <= vc_q[3];
		end
		if (cmd.ext_en) begin
			hw_q <= (ext_w_c < mw_q) ? mw_q : ext_w_c;
			hh_q <= (ext_h_c < mh_q) ? mh_q : ext_h_c;
		end
		if (cmd.ep_en) begin
			if (cmd.ep_e1) e1_q <= ep_c;
			else e0_q <= ep_c;
		end
		if (cmd.sel_en) begin
			sel_q[1] <= !(p_q[0] < p_q[1]);
			sel_q[0] <= !(p_q[2] < p_q[3]);
		end
	end

	logic [1:0] code_c;
	endpoint_t  src_c;
	assign code_c   = CORNER_ORDER[sel_q][cmd.k];
	assign src_c    = (cmd.k < 3'd3) ? e0_q : e1_q;
	assign clip_x   = code_c[0] ? src_c.r : src_c.l;
	assign clip_y   = code_c[1] ? src_c.b : src_c.t;
	assign clip_z   = src_c.z;
	assign clip_w   = src_c.w;
	assign out_u    = src_c.u;
	assign out_v    = src_c.v;
	assign out_rgba = src_c.color;
	assign last     = (cmd.k == 3'd5);

endmodule

FILE: hdl/thick_line_hexagon_expander.sv
// Top level of the thick line hexagon expander.
`timescale 1ns / 1ps
// Input transactions either load one matrix word (op 0, no output, the block stays idle) or
// deliver one line vertex (op 1). All multiplies run on one shared 32x32 multiplier with a
// three-stage pipeline (memory read, multiply, scale and accumulate), so the vertex cost is set
// by the number of multiplies: 16 transform terms and two extent scalings in screen-space mode,
// 48 transform terms, the half width and two minimum extents in view-space mode, plus
// pipeline drains between dependent steps. The first vertex of a pair is held and produces
// nothing; the second adds the four cross products of the corner test and then presents six
// output transactions, one per cycle while the output is not stalled, with last set on the
// sixth. No new input is taken until the sixth output transaction completes. Configuration
// registers are written through cfg_we, cfg_index and cfg_wdata; the user must do so only
// while the block is idle, which the block itself does not enforce. Matrix words that were
// never loaded read as unknown.
module thick_line_hexagon_expander
	import tlhe_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [30:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [5:0]         word_index,
	input  logic signed [31:0] word_value,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] tex_u,
	input  logic signed [31:0] tex_v,
	input  logic [31:0]        rgba,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] clip_x,
	output logic signed [31:0] clip_y,
	output logic signed [31:0] clip_z,
	output logic signed [31:0] clip_w,
	output logic signed [31:0] out_u,
	output logic signed [31:0] out_v,
	output logic [31:0]        out_rgba,
	output logic               last
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// The controller sequences every step; the datapath follows only its commands and cfg writes.
	tlhe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	tlhe_dpath #(
		.FRAC_BITS (FRAC_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.word_index (word_index),
		.word_value (word_value),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.tex_u      (tex_u),
		.tex_v      (tex_v),
		.rgba       (rgba),
		.clip_x     (clip_x),
		.clip_y     (clip_y),
		.clip_z     (clip_z),
		.clip_w     (clip_w),
		.out_u      (out_u),
		.out_v      (out_v),
		.out_rgba   (out_rgba),
		.last       (last)
	);

endmodule

FILE: test/tb.sv
// Self-checking testbench for the thick line hexagon expander.
`timescale 1ns / 1ps
module tb;
	import tlhe_pkg::*;

	// One expected hexagon vertex as it should leave the output channel.
	typedef struct packed {
		logic signed [31:0] x, y, z, w, u, v;
		logic [31:0]        rgba;
		logic               last;
	} corner_t;

	// A rectangular endpoint: left, right, top, bottom, then pass-through values.
	typedef struct {
		int l, r, t, b, z, w, u, v;
		logic [31:0] rgba;
	} endpoint_t;

	// The scoreboard keeps its own copy of the matrices, the registers and the held
	// endpoint, predicts the corners of each segment and checks the output against them.
	class hexagon_scoreboard;
		int        mat [48];
		bit        mode;
		int        view_w, half_x, half_y, min_x, min_y;
		endpoint_t held;
		bit        second;
		corner_t   corners_due [$];
		int        errors;
		int        corners_seen;
		int        segments;
		int        order [4][6] = '{
			'{3, 2, 0, 0, 1, 3}, '{1, 3, 2, 2, 0, 1},
			'{2, 0, 1, 1, 3, 2}, '{0, 1, 3, 3, 2, 0}};

		function new();
			mode = 0;
			view_w = 65536;
			half_x = 0;
			half_y = 0;
			min_x = 0;
			min_y = 0;
			second = 0;
			errors = 0;
			corners_seen = 0;
			segments = 0;
			foreach (mat[i]) mat[i] = 0;
		endfunction

		function int sat(longint v);
			if (v > 64'sd2147483647) return 32'sh7fffffff;
			if (v < -64'sd2147483648) return 32'sh80000000;
			return int'(v);
		endfunction

		// Q product: exact, floored by the arithmetic shift, then saturated.
		function int qmul(int a, int b);
			longint p;
			p = longint'(a) * longint'(b);
			return sat(p >>> FRAC_BITS_DEF);
		endfunction

		// Row vector times a 4x4 row-major matrix starting at word base.
		function void xform(input int vin [4], input int base, output int vo [4]);
			longint acc;
			for (int j = 0; j < 4; j++) begin
				acc = 0;
				for (int i = 0; i < 4; i++)
					acc += qmul(vin[i], mat[base + i * 4 + j]);
				vo[j] = sat(acc);
			end
		endfunction

		function int abs_diff(int a, int b);
			longint d;
			d = longint'(a) - longint'(b);
			if (d < 0) d = -d;
			return sat(d);
		endfunction

		function void set_reg(logic [2:0] idx, logic [30:0] val);
			case (idx)
				CFG_MODE:   mode = val[0];
				CFG_VIEW_W: view_w = int'({1'b0, val});
				CFG_HALF_X: half_x = int'({1'b0, val});
				CFG_HALF_Y: half_y = int'({1'b0, val});
				CFG_MIN_X:  min_x = int'({1'b0, val});
				CFG_MIN_Y:  min_y = int'({1'b0, val});
				default: ;
			endcase
		endfunction

		function endpoint_t build(int px, int py, int pz, int tu, int tv, logic [31:0] col);
			endpoint_t e;
			int vin [4], c [4], vc [4], tl [4], tc [4];
			int hw, hh, hs, mw, mh;
			vin = '{px, py, pz, 32'sd1 <<< FRAC_BITS_DEF};
			if (mode) begin
				xform(vin, BASE_WVP, c);
				hw = qmul(half_x, c[3]);
				hh = qmul(half_y, c[3]);
			end else begin
				xform(vin, BASE_WV, vc);
				hs = sat((longint'(view_w) * longint'(vc[3])) >>> (FRAC_BITS_DEF + 1));
				tl[0] = sat(longint'(vc[0]) - hs);
				tl[1] = sat(longint'(vc[1]) + hs);
				tl[2] = vc[2];
				tl[3] = vc[3];
				xform(vc, BASE_PROJ, c);
				xform(tl, BASE_PROJ, tc);
				hw = abs_diff(tc[0], c[0]);
				hh = abs_diff(tc[1], c[1]);
				mw = qmul(min_x, c[3]);
				mh = qmul(min_y, c[3]);
				if (hw < mw) hw = mw;
				if (hh < mh) hh = mh;
			end
			e.l = sat(longint'(c[0]) - hw);
			e.r = sat(longint'(c[0]) + hw);
			e.t = sat(longint'(c[1]) + hh);
			e.b = sat(longint'(c[1]) - hh);
			e.z = c[2];
			e.w = c[3];
			e.u = tu;
			e.v = tv;
			e.rgba = col;
			return e;
		endfunction

		// Called for every accepted input transaction.
		function void note_input(logic op_i, logic [5:0] idx, int wv, int px, int py, int pz,
				int tu, int tv, logic [31:0] col);
			endpoint_t e1, src;
			int sel, code;
			corner_t cr;
			if (!op_i) begin
				if (idx < MAT_WORDS) mat[idx] = wv;
				return;
			end
			if (!second) begin
				held = build(px, py, pz, tu, tv, col);
				second = 1;
				return;
			end
			e1 = build(px, py, pz, tu, tv, col);
			second = 0;
			segments++;
			sel = 0;
			if (!(longint'(held.t) * e1.w < longint'(e1.t) * held.w)) sel |= 2;
			if (!(longint'(held.l) * e1.w < longint'(e1.l) * held.w)) sel |= 1;
			for (int k = 0; k < 6; k++) begin
				src = (k < 3) ? held : e1;
				code = order[sel][k];
				cr.x = code[0] ? src.r : src.l;
				cr.y = code[1] ? src.b : src.t;
				cr.z = src.z;
				cr.w = src.w;
				cr.u = src.u;
				cr.v = src.v;
				cr.rgba = src.rgba;
				cr.last = (k == 5);
				corners_due.push_back(cr);
			end
		endfunction

		// Called for every accepted output transaction.
		function void check_corner(corner_t got);
			corner_t want;
			corners_seen++;
			if (corners_due.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected output transaction x=%h", got.x);
				return;
			end
			want = corners_due.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch: exp x=%h y=%h z=%h w=%h u=%h v=%h c=%h l=%b",
						want.x, want.y, want.z, want.w, want.u, want.v, want.rgba, want.last);
					$display("          got x=%h y=%h z=%h w=%h u=%h v=%h c=%h l=%b",
						got.x, got.y, got.z, got.w, got.u, got.v, got.rgba, got.last);
				end
			end
		endfunction
	endclass

	logic               clk = 0;
	logic               arst_n = 0;
	logic               cfg_we = 0;
	logic [2:0]         cfg_index = '0;
	logic [30:0]        cfg_wdata = '0;
	logic               in_valid = 0;
	logic               in_stall;
	logic               op = 0;
	logic [5:0]         word_index = '0;
	logic signed [31:0] word_value = '0;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0, tex_u = '0, tex_v = '0;
	logic [31:0]        rgba = '0;
	logic               out_valid;
	logic               out_stall = 0;
	logic signed [31:0] clip_x, clip_y, clip_z, clip_w, out_u, out_v;
	logic [31:0]        out_rgba;
	logic               last;

	hexagon_scoreboard sb = new();

	// Idling control: random bursts on both sides while gaps_on is set; hold_req asks the
	// receiver for one long stall so the block backs up into its input.
	bit gaps_on = 1;
	bit hold_req = 0;
	int quiet_cycles = 0;
	int loads_sent = 0;
	int vertices_sent = 0;

	localparam int WATCHDOG_LIMIT = 6000;
	localparam int DRAIN_CYCLES = 150;

	thick_line_hexagon_expander DUT (.*);

	always #4 clk = ~clk;

	// The prediction is advanced on each accepted input transaction. Values are read in the
	// active region of the edge, before any nonblocking update of that edge lands.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_input(op, word_index, word_value, pos_x, pos_y, pos_z, tex_u, tex_v, rgba);
	end

	always @(posedge clk) begin
		corner_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.x = clip_x;
			got.y = clip_y;
			got.z = clip_z;
			got.w = clip_w;
			got.u = out_u;
			got.v = out_v;
			got.rgba = out_rgba;
			got.last = last;
			sb.check_corner(got);
		end
	end

	// The watchdog counts cycles in which neither channel moves a transaction.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Receiver: random stall bursts, a long counted hold when asked, none in the quiet tail.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1;
				repeat (400) @(posedge clk);
				out_stall <= 0;
				hold_req = 0;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 15);
				out_stall <= 1;
				repeat (n) @(posedge clk);
				out_stall <= 0;
			end
		end
	end

	// A Q value: mostly moderate, sometimes fully random or at the extremes.
	function automatic logic [31:0] any_q();
		case ($urandom_range(0, 9))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2, 3: return $urandom;
			default: return $urandom_range(0, 32'h80000) - 32'h40000;
		endcase
	endfunction

	function automatic logic [30:0] any_reg();
		case ($urandom_range(0, 7))
			0: return 31'd0;
			1: return 31'h7fffffff;
			2: return 31'($urandom);
			default: return 31'($urandom_range(0, 32'h20000));
		endcase
	endfunction

	// Presents one transaction and returns at the edge where it is accepted. A gap, if any,
	// drops valid first, so valid is never lowered and raised within one time step.
	task automatic send(logic o, logic [5:0] idx, logic [31:0] wv, logic [31:0] px,
			logic [31:0] py, logic [31:0] pz, logic [31:0] tu, logic [31:0] tv, logic [31:0] col);
		int n;
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 15);
			in_valid <= 0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1;
		op <= o;
		word_index <= idx;
		word_value <= wv;
		pos_x <= px;
		pos_y <= py;
		pos_z <= pz;
		tex_u <= tu;
		tex_v <= tv;
		rgba <= col;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (o) vertices_sent++;
		else loads_sent++;
	endtask

	task automatic load_word(logic [5:0] idx, logic [31:0] val);
		send(1'b0, idx, val, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic send_vertex(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
		send(1'b1, 6'($urandom), $urandom, px, py, pz, $urandom, $urandom, $urandom);
	endtask

	// Waits until every predicted corner has arrived, then lets the block settle, since a
	// word load or a held first vertex can still be in flight with nothing expected.
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (sb.corners_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [30:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, val);
	endtask

	// Loads count matrix words from word first on: identity-like with moderate entries, or
	// mixed Q values that are mostly moderate, sometimes fully random or at the extremes.
	task automatic load_matrices(bit wild, int first, int count);
		logic [31:0] val;
		for (int a = first; a < first + count; a++) begin
			if (wild)
				val = any_q();
			else if ((a % 16) % 5 == 0)
				val = 32'h10000 + $urandom_range(0, 32'h8000) - 32'h4000;
			else
				val = $urandom_range(0, 32'h10000) - 32'h8000;
			load_word(a[5:0], val);
		end
	endtask

	initial begin
		logic [31:0] px, py, pz;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part: clean matrices, both modes, extreme positions, ignored loads.
		load_matrices(0, 0, MAT_WORDS);
		load_word(6'd48, $urandom);
		load_word(6'd63, 32'h7fffffff);
		send_vertex(32'h0, 32'h0, 32'h0);
		send_vertex(32'h10000, 32'h20000, 32'h0);
		send_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		send_vertex(32'h80000000, 32'h80000000, 32'h80000000);
		send_vertex(32'hfff00000, 32'h00100000, 32'h00030000);
		send_vertex(32'h00100000, 32'hfff00000, 32'hfffd0000);
		drain();
		write_reg(CFG_MODE, 31'd1);
		write_reg(CFG_HALF_X, 31'h8000);
		write_reg(CFG_HALF_Y, 31'h7fffffff);
		send_vertex(32'h10000, 32'h10000, 32'h0);
		send_vertex(32'hffff0000, 32'h30000, 32'h0);
		send_vertex(32'h7fffffff, 32'h80000000, 32'h10000);
		send_vertex(32'h80000000, 32'h7fffffff, 32'h10000);
		drain();
		write_reg(CFG_MODE, 31'd0);
		write_reg(CFG_VIEW_W, 31'h7fffffff);
		write_reg(CFG_MIN_X, 31'h7fffffff);
		write_reg(CFG_MIN_Y, 31'd0);
		send_vertex(32'h20000, 32'h0, 32'h0);
		send_vertex(32'h0, 32'h20000, 32'h0);
		drain();

		// Random part: eight phases, each with its own register setting and the matrices
		// that its mode uses reloaded.
		for (int ph = 0; ph < 8; ph++) begin
			gaps_on = (ph < 7);
			write_reg(CFG_MODE, ph[0] ? 31'd1 : 31'd0);
			write_reg(CFG_VIEW_W, ph == 2 ? 31'd0 : any_reg());
			write_reg(CFG_HALF_X, ph == 3 ? 31'h7fffffff : any_reg());
			write_reg(CFG_HALF_Y, ph == 5 ? 31'd0 : any_reg());
			write_reg(CFG_MIN_X, any_reg());
			write_reg(CFG_MIN_Y, ph == 4 ? 31'h7fffffff : any_reg());
			if (ph[0])
				load_matrices(ph == 6, int'(BASE_WVP), 16);
			else
				load_matrices(ph == 6, int'(BASE_WV), 32);
			if (ph == 2) hold_req = 1;
			for (int n = 0; n < 16; n++) begin
				if ($urandom_range(0, 9) == 0) begin
					load_word(6'($urandom), any_q());
				end else begin
					px = any_q();
					py = any_q();
					pz = any_q();
					send_vertex(px, py, pz);
				end
			end
			drain();
		end

		$display("tb: %0d vertices and %0d word loads sent, %0d segments, %0d corners checked",
			vertices_sent, loads_sent, sb.segments, sb.corners_seen);
		$display("tb: both width modes, register extremes, ignored loads and a long output hold");
		if (sb.errors == 0 && sb.corners_due.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: %0d mismatches, %0d corners outstanding", sb.errors,
				sb.corners_due.size());
			$display("tb: failure");
		end
		$finish;
	end
endmodule

FILE: filelist.f
hdl/tlhe_pkg.sv
hdl/tlhe_ctrl.sv
hdl/tlhe_dpath.sv
hdl/thick_line_hexagon_expander.sv
test/tb.sv
